@@ design/dtq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the timer queue.
`default_nettype none
package dtq_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 5;
  localparam int MAX_RESULTS = 16;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCHED_TRY,
    S_SCAN_START,
    S_SCAN,
    S_DECIDE,
    S_EMIT_MORE,
    S_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic load;
    logic set_full;
    logic sched_try;
    logic cancel;
    logic scan_start;
    logic scan_step;
    logic purge;
    logic fire;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       cand_ok;
    logic       scan_last;
    logic       head_valid;
    logic       head_cancelled;
    logic       head_due;
    logic       pending;
    logic       fire_room;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/dtq_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`default_nettype none
module dtq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  dtq_pkg::sts_t      sts,
  output dtq_pkg::cmd_t      cmd
);
  import dtq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          KIND_SCHED: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_SCAN_START;
            end else begin
              state_nxt = S_SCHED_TRY;
            end
          end
          KIND_CANCEL: begin
            cmd.cancel = 1'b1;
            state_nxt  = S_SCAN_START;
          end
          default: state_nxt = S_SCAN_START;
        endcase
      end
      S_SCHED_TRY: begin
        cmd.sched_try = 1'b1;
        if (sts.cand_ok) begin
          state_nxt = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.kind != KIND_RUN) begin
          state_nxt = S_EMIT_LAST;
        end else if (sts.head_valid && sts.head_cancelled && sts.fire_room) begin
          cmd.purge = 1'b1;
          state_nxt = S_SCAN_START;
        end else if (sts.head_valid && sts.head_due && sts.fire_room) begin
          if (sts.pending) begin
            state_nxt = S_EMIT_MORE;
          end else begin
            cmd.fire  = 1'b1;
            state_nxt = S_SCAN_START;
          end
        end else begin
          state_nxt = S_EMIT_LAST;
        end
      end
      S_EMIT_MORE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.fire  = 1'b1;
          state_nxt = S_SCAN_START;
        end
      end
      S_EMIT_LAST: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ design/dtq_dp.sv @@
// Datapath with the timer table, id counter, ordering scan and result register.
`default_nettype none
module dtq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [dtq_pkg::TIME_W-1:0]    in_deadline,
  input  wire logic [dtq_pkg::ID_W-1:0]      in_cancel_id,
  input  wire logic [dtq_pkg::TIME_W-1:0]    in_now_tick,
  input  dtq_pkg::cmd_t                      cmd,
  output dtq_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [dtq_pkg::ID_W-1:0]           out_timer_id,
  output logic                               out_fired,
  output logic                               out_last,
  output logic [dtq_pkg::CNT_W-1:0]          out_live_count,
  output logic                               out_has_next,
  output logic [dtq_pkg::TIME_W-1:0]         out_next_deadline
);
  import dtq_pkg::*;

  logic [DEPTH-1:0]  used_r, canc_r;
  logic [TIME_W-1:0] dl_r [DEPTH];
  logic [ID_W-1:0]   id_r [DEPTH];
  logic [ID_W-1:0]   id_cnt_r;

  logic [1:0]        kind_r;
  logic [TIME_W-1:0] deadline_r, now_r;
  logic [ID_W-1:0]   cancel_id_r;
  logic [1:0]        res_status_r;
  logic [ID_W-1:0]   res_id_r;
  logic              res_fired_r;
  logic [CNT_W-1:0]  fire_cnt_r;

  logic [IDX_W-1:0]  j_r;
  logic              all_v_r, live_v_r;
  logic [IDX_W-1:0]  all_idx_r;
  logic [TIME_W-1:0] all_dl_r, live_dl_r;
  logic [ID_W-1:0]   all_id_r, live_id_r;
  logic [CNT_W-1:0]  live_cnt_r;

  logic              out_valid_r;
  logic              out_fired_r, out_last_r, out_has_next_r;
  logic [1:0]        out_status_r;
  logic [ID_W-1:0]   out_timer_id_r;
  logic [CNT_W-1:0]  out_live_count_r;
  logic [TIME_W-1:0] out_next_deadline_r;

  logic [IDX_W-1:0]  free_idx, match_idx;
  logic              held, match;
  logic              cand_ok, cancel_ok;
  logic              j_used, j_canc;
  logic [TIME_W-1:0] j_dl;
  logic [ID_W-1:0]   j_id;
  logic              j_before_all, j_before_live;

  always_comb begin
    free_idx  = '0;
    held      = 1'b0;
    match     = 1'b0;
    match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (used_r[i] && id_r[i] == id_cnt_r) begin
        held = 1'b1;
      end
      if (used_r[i] && id_r[i] == cancel_id_r) begin
        match     = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  assign cand_ok   = (id_cnt_r != '0) && !held;
  assign cancel_ok = (cancel_id_r != '0) && match && !canc_r[match_idx];

  assign j_used = used_r[j_r];
  assign j_canc = canc_r[j_r];
  assign j_dl   = dl_r[j_r];
  assign j_id   = id_r[j_r];
  assign j_before_all  = (j_dl < all_dl_r) || (j_dl == all_dl_r && j_id < all_id_r);
  assign j_before_live = (j_dl < live_dl_r) || (j_dl == live_dl_r && j_id < live_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      canc_r   <= '0;
      id_cnt_r <= ID_W'(1);
    end else begin
      if (cmd.sched_try) begin
        id_cnt_r <= id_cnt_r + ID_W'(1);
        if (cand_ok) begin
          used_r[free_idx] <= 1'b1;
          canc_r[free_idx] <= 1'b0;
        end
      end
      if (cmd.cancel && cancel_ok) begin
        canc_r[match_idx] <= 1'b1;
      end
      if (cmd.purge || cmd.fire) begin
        used_r[all_idx_r] <= 1'b0;
        canc_r[all_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_try && cand_ok) begin
      dl_r[free_idx] <= deadline_r;
      id_r[free_idx] <= id_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= in_kind;
      deadline_r   <= in_deadline;
      now_r        <= in_now_tick;
      cancel_id_r  <= in_cancel_id;
      res_status_r <= ST_OK;
      res_id_r     <= '0;
      res_fired_r  <= 1'b0;
      fire_cnt_r   <= '0;
    end
    if (cmd.set_full) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.sched_try && cand_ok) begin
      res_id_r <= id_cnt_r;
    end
    if (cmd.cancel && !cancel_ok) begin
      res_status_r <= ST_REJECTED;
    end
    if (cmd.fire) begin
      res_id_r    <= all_id_r;
      res_fired_r <= 1'b1;
      fire_cnt_r  <= fire_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      j_r        <= '0;
      all_v_r    <= 1'b0;
      live_v_r   <= 1'b0;
      live_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      j_r <= j_r + IDX_W'(1);
      if (j_used && (!all_v_r || j_before_all)) begin
        all_v_r   <= 1'b1;
        all_idx_r <= j_r;
        all_dl_r  <= j_dl;
        all_id_r  <= j_id;
      end
      if (j_used && !j_canc) begin
        live_cnt_r <= live_cnt_r + CNT_W'(1);
        if (!live_v_r || j_before_live) begin
          live_v_r  <= 1'b1;
          live_dl_r <= j_dl;
          live_id_r <= j_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r        <= res_status_r;
      out_timer_id_r      <= res_id_r;
      out_fired_r         <= res_fired_r;
      out_last_r          <= cmd.emit_last;
      out_live_count_r    <= live_cnt_r;
      out_has_next_r      <= live_v_r;
      out_next_deadline_r <= live_v_r ? live_dl_r : '0;
    end
  end

  always_comb begin
    sts                = '0;
    sts.kind           = kind_r;
    sts.full           = &used_r;
    sts.cand_ok        = cand_ok;
    sts.scan_last      = (j_r == IDX_W'(DEPTH - 1));
    sts.head_valid     = all_v_r;
    sts.head_cancelled = canc_r[all_idx_r];
    sts.head_due       = (all_dl_r <= now_r);
    sts.pending        = res_fired_r;
    sts.fire_room      = (fire_cnt_r < CNT_W'(MAX_RESULTS));
    sts.out_free       = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_timer_id      = out_timer_id_r;
  assign out_fired         = out_fired_r;
  assign out_last          = out_last_r;
  assign out_live_count    = out_live_count_r;
  assign out_has_next      = out_has_next_r;
  assign out_next_deadline = out_next_deadline_r;

  a_fire_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire || cmd.purge) |=> !used_r[$past(all_idx_r)])
    else $error("fired or purged slot still occupied");

  a_sched_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sched_try && cand_ok) |=> used_r[$past(free_idx)] && !canc_r[$past(free_idx)])
    else $error("scheduled slot not occupied");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> fire_cnt_r < CNT_W'(MAX_RESULTS))
    else $error("too many timers fired for one request");

endmodule
`default_nettype wire

@@ design/deadline_timer_queue.sv @@
// Top level of the deadline-ordered timer queue: controller plus datapath.
// A schedule steps the id counter until it finds a free nonzero id; cancel and other kinds scan the table once.
// A run rescans the table after each purged cancelled timer and after each fired timer.
// Each table scan walks the 16 slots one per cycle; one request is processed at a time.
// A finished result waits in an output register while the next request is accepted.
// Synchronous active-low reset empties the table, sets the id counter to one, drops out_valid.
`default_nettype none
module deadline_timer_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [dtq_pkg::TIME_W-1:0]    in_deadline,
  input  wire logic [dtq_pkg::ID_W-1:0]      in_cancel_id,
  input  wire logic [dtq_pkg::TIME_W-1:0]    in_now_tick,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [dtq_pkg::ID_W-1:0]           out_timer_id,
  output logic                               out_fired,
  output logic                               out_last,
  output logic [dtq_pkg::CNT_W-1:0]          out_live_count,
  output logic                               out_has_next,
  output logic [dtq_pkg::TIME_W-1:0]         out_next_deadline
);
  import dtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_deadline       (in_deadline),
    .in_cancel_id      (in_cancel_id),
    .in_now_tick       (in_now_tick),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_timer_id      (out_timer_id),
    .out_fired         (out_fired),
    .out_last          (out_last),
    .out_live_count    (out_live_count),
    .out_has_next      (out_has_next),
    .out_next_deadline (out_next_deadline)
  );

endmodule
`default_nettype wire

@@ tb/tb_deadline_timer_queue.sv @@
// Self-checking testbench for the deadline timer queue, with a directed table and random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   timer_id;
    logic              fired;
    logic              last;
    logic [CNT_W-1:0]  live_count;
    logic              has_next;
    logic [TIME_W-1:0] next_deadline;
  } timer_result_t;

  typedef struct {
    logic [1:0]        kind;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   cancel_id;
    logic [TIME_W-1:0] now_tick;
    bit                typed;
    logic [1:0]        status;
    logic [ID_W-1:0]   timer_id;
  } timer_request_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_kind;
  logic [TIME_W-1:0] in_deadline;
  logic [ID_W-1:0] in_cancel_id;
  logic [TIME_W-1:0] in_now_tick;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [ID_W-1:0] out_timer_id;
  logic out_fired;
  logic out_last;
  logic [CNT_W-1:0] out_live_count;
  logic out_has_next;
  logic [TIME_W-1:0] out_next_deadline;

  deadline_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_deadline(in_deadline), .in_cancel_id(in_cancel_id), .in_now_tick(in_now_tick),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_timer_id(out_timer_id), .out_fired(out_fired), .out_last(out_last),
    .out_live_count(out_live_count), .out_has_next(out_has_next),
    .out_next_deadline(out_next_deadline)
  );

  bit                slot_busy [DEPTH];
  bit                slot_dead [DEPTH];
  logic [TIME_W-1:0] slot_due [DEPTH];
  logic [ID_W-1:0]   slot_tid [DEPTH];
  logic [ID_W-1:0]   next_id;

  timer_result_t  pending_results [$];
  timer_request_t directed [$];
  int error_count;
  int cycle_count;
  int rx_wait;
  bit stim_done;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic bit orders_first(input int a, input int b);
    if (slot_due[a] != slot_due[b]) return slot_due[a] < slot_due[b];
    return slot_tid[a] < slot_tid[b];
  endfunction

  function automatic int table_head(input bit live_only);
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_busy[i] || (live_only && slot_dead[i])) continue;
      if (best < 0 || orders_first(i, best)) best = i;
    end
    return best;
  endfunction

  function automatic timer_result_t table_summary(input logic [1:0] st,
                                                  input logic [ID_W-1:0] tid,
                                                  input logic fired);
    timer_result_t r;
    int live;
    int h;
    live = 0;
    for (int i = 0; i < DEPTH; i++) if (slot_busy[i] && !slot_dead[i]) live++;
    h = table_head(1'b1);
    r.status = st;
    r.timer_id = tid;
    r.fired = fired;
    r.last = 1'b1;
    r.live_count = live[CNT_W-1:0];
    r.has_next = (h >= 0);
    r.next_deadline = (h >= 0) ? slot_due[h] : '0;
    return r;
  endfunction

  function automatic bit id_in_table(input logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) if (slot_busy[i] && slot_tid[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_timers(input timer_request_t q);
    int free_slot;
    int h;
    int count;
    logic [ID_W-1:0] cand;
    bit done;
    timer_result_t r;
    done = 1'b0;
    case (q.kind)
      KIND_SCHED: begin
        free_slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) if (!slot_busy[i]) free_slot = i;
        if (free_slot < 0) begin
          pending_results.push_back(table_summary(ST_FULL, '0, 1'b0));
        end else begin
          for (int i = 0; i < DEPTH + 2 && !done; i++) begin
            cand = next_id;
            next_id = next_id + 1'b1;
            if (cand != 0 && !id_in_table(cand)) begin
              slot_busy[free_slot] = 1'b1;
              slot_dead[free_slot] = 1'b0;
              slot_due[free_slot] = q.deadline;
              slot_tid[free_slot] = cand;
              pending_results.push_back(table_summary(ST_OK, cand, 1'b0));
              done = 1'b1;
            end
          end
          if (!done) pending_results.push_back(table_summary(ST_FULL, '0, 1'b0));
        end
      end
      KIND_CANCEL: begin
        if (q.cancel_id != 0) begin
          for (int i = 0; i < DEPTH && !done; i++) begin
            if (slot_busy[i] && slot_tid[i] == q.cancel_id) begin
              done = 1'b1;
              if (!slot_dead[i]) begin
                slot_dead[i] = 1'b1;
                pending_results.push_back(table_summary(ST_OK, '0, 1'b0));
              end else begin
                pending_results.push_back(table_summary(ST_REJECTED, '0, 1'b0));
              end
            end
          end
        end
        if (!done) pending_results.push_back(table_summary(ST_REJECTED, '0, 1'b0));
      end
      KIND_RUN: begin
        count = 0;
        while (count < MAX_RESULTS && !done) begin
          h = table_head(1'b0);
          while (h >= 0 && slot_dead[h]) begin
            slot_busy[h] = 1'b0;
            slot_dead[h] = 1'b0;
            h = table_head(1'b0);
          end
          if (h < 0 || slot_due[h] > q.now_tick) begin
            done = 1'b1;
          end else begin
            slot_busy[h] = 1'b0;
            if (count > 0) begin
              r = pending_results.pop_back();
              r.last = 1'b0;
              pending_results.push_back(r);
            end
            pending_results.push_back(table_summary(ST_OK, slot_tid[h], 1'b1));
            count++;
          end
        end
        if (count == 0) pending_results.push_back(table_summary(ST_OK, '0, 1'b0));
      end
      default: pending_results.push_back(table_summary(ST_OK, '0, 1'b0));
    endcase
  endtask

  task automatic send_request(input timer_request_t q);
    int gap;
    timer_result_t r;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= q.kind;
    in_deadline <= q.deadline;
    in_cancel_id <= q.cancel_id;
    in_now_tick <= q.now_tick;
    do @(posedge clk); while (in_stall);
    predict_timers(q);
    if (q.typed) begin
      r = pending_results[$];
      if (r.status != q.status || r.timer_id != q.timer_id)
        report_mismatch($sformatf("table row kind %0d: predictor %0d/%0h, table %0d/%0h",
                                  q.kind, r.status, r.timer_id, q.status, q.timer_id));
    end
  endtask

  function automatic timer_request_t make_request(input logic [1:0] kind,
                                                  input logic [TIME_W-1:0] deadline,
                                                  input logic [ID_W-1:0] cid,
                                                  input logic [TIME_W-1:0] now,
                                                  input bit typed = 1'b0,
                                                  input logic [1:0] st = ST_OK,
                                                  input logic [ID_W-1:0] tid = '0);
    timer_request_t q;
    q.kind = kind; q.deadline = deadline; q.cancel_id = cid; q.now_tick = now;
    q.typed = typed; q.status = st; q.timer_id = tid;
    return q;
  endfunction

  function automatic logic [ID_W-1:0] some_held_id();
    int pick;
    pick = $urandom_range(0, DEPTH - 1);
    for (int i = 0; i < DEPTH; i++)
      if (slot_busy[(pick + i) % DEPTH]) return slot_tid[(pick + i) % DEPTH];
    return ID_W'($urandom_range(0, 65535));
  endfunction

  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      draw = $urandom_range(0, 11);
      rx_wait <= draw;
      out_stall <= long_hold || (draw != 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= long_hold || (rx_wait != 1);
    end else begin
      out_stall <= long_hold;
    end
  end

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_timer_id, out_fired, out_last, out_live_count,
              out_has_next, out_next_deadline};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status");
        if (got.timer_id != want.timer_id) report_mismatch("timer_id");
        if (got.fired != want.fired) report_mismatch("fired");
        if (got.last != want.last) report_mismatch("last");
        if (got.live_count != want.live_count) report_mismatch("live_count");
        if (got.has_next != want.has_next) report_mismatch("has_next");
        if (got.next_deadline != want.next_deadline) report_mismatch("next_deadline");
      end
    end
    if (cycle_count > 900000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int hold;
    wait (stim_done == 1'b0 && rst_n === 1'b1);
    repeat (400) @(posedge clk);
    long_hold <= 1'b1;
    hold = 0;
    while (hold < 600) begin
      @(posedge clk);
      hold++;
    end
    long_hold <= 1'b0;
  end

  initial begin
    int k;
    logic [TIME_W-1:0] base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_SCHED;
    in_deadline = '0;
    in_cancel_id = '0;
    in_now_tick = '0;
    out_stall = 1'b0;
    rx_wait = 0;
    long_hold = 1'b0;
    stim_done = 1'b0;
    error_count = 0;
    cycle_count = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_busy[i] = 1'b0; slot_dead[i] = 1'b0; slot_due[i] = '0; slot_tid[i] = '0;
    end
    next_id = 1;

    directed.push_back(make_request(KIND_RUN, '0, '0, '1, 1, ST_OK, 0));
    directed.push_back(make_request(KIND_CANCEL, '0, '0, '0, 1, ST_REJECTED, 0));
    directed.push_back(make_request(KIND_CANCEL, '0, '1, '0, 1, ST_REJECTED, 0));
    directed.push_back(make_request(KIND_SCHED, '1, '0, '0, 1, ST_OK, 1));
    directed.push_back(make_request(KIND_SCHED, '0, '0, '0, 1, ST_OK, 2));
    directed.push_back(make_request(KIND_SCHED, 32'd50, '0, '0, 1, ST_OK, 3));
    directed.push_back(make_request(KIND_SCHED, 32'd50, '0, '0, 1, ST_OK, 4));
    directed.push_back(make_request(KIND_CANCEL, '0, 16'd2, '0, 1, ST_OK, 0));
    directed.push_back(make_request(KIND_CANCEL, '0, 16'd2, '0, 1, ST_REJECTED, 0));
    directed.push_back(make_request(KIND_NOP, '1, '1, '1, 1, ST_OK, 0));
    directed.push_back(make_request(KIND_RUN, '0, '0, 32'd49));
    directed.push_back(make_request(KIND_RUN, '0, '0, 32'd50));
    for (int i = 0; i < 16; i++)
      directed.push_back(make_request(KIND_SCHED, 32'd100 - i, '0, '0));
    directed.push_back(make_request(KIND_SCHED, '0, '0, '0, 1, ST_FULL, 0));
    directed.push_back(make_request(KIND_CANCEL, '0, 16'd7, '0));
    directed.push_back(make_request(KIND_RUN, '0, '0, '1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_request(directed[i]);

    k = 0;
    base = 32'd1000;
    while (k < 300) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request(make_request(KIND_SCHED,
                      ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                  : base + $urandom_range(0, 200),
                      ID_W'($urandom), TIME_W'($urandom)));
        4, 5: send_request(make_request(KIND_CANCEL, TIME_W'($urandom),
                ($urandom_range(0, 4) == 0) ? ID_W'($urandom) : some_held_id(),
                TIME_W'($urandom)));
        6, 7, 8: begin
          send_request(make_request(KIND_RUN, TIME_W'($urandom), ID_W'($urandom),
                       ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                   : base + $urandom_range(0, 150)));
          base = base + $urandom_range(0, 60);
        end
        default: send_request(make_request(KIND_NOP, TIME_W'($urandom), ID_W'($urandom),
                   TIME_W'($urandom)));
      endcase
      k++;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
design/dtq_pkg.sv
design/dtq_ctrl.sv
design/dtq_dp.sv
design/deadline_timer_queue.sv
tb/tb_deadline_timer_queue.sv
